// ===== sv/csm_pkg.sv =====
// Shared types and constants for the cron schedule matcher.
// Used by cron_schedule_matcher and csm_checker; no dependencies.
package csm_pkg;

    localparam int Slots   = 16;
    localparam int MaxHits = 16;

    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_WRITE  = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    localparam logic [5:0] MinuteMax = 6'd59;
    localparam logic [4:0] HourMax   = 5'd23;
    localparam logic [4:0] MonthMax  = 5'd12;
    localparam logic [2:0] WeekdayNone = 3'd7;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [3:0]  slot;
        logic [59:0] minute_mask;
        logic [23:0] hour_mask;
        logic [31:0] day_mask;
        logic [12:0] month_mask;
        logic [6:0]  week_mask;
        logic [1:0]  restrict_flags;
        logic        oneshot;
        logic [31:0] time_stamp;
        logic [2:0]  weekday;
    } t_req;

    typedef struct packed {
        logic [3:0] hit_slot;
        logic       last_hit;
    } t_res;

    // one rule memory word
    typedef struct packed {
        logic [59:0] minute_mask;
        logic [23:0] hour_mask;
        logic [31:0] day_mask;
        logic [12:0] month_mask;
        logic [6:0]  week_mask;
        logic [1:0]  restrict_flags;
        logic        oneshot;
    } t_rule;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

endpackage

// ===== sv/cron_schedule_matcher.sv =====
// Cron rule table: rule memory, last-stamp memory and a one-slot-per-cycle scan.
// Depends on csm_pkg.
//
//  channel   | handshake           | payload           | direction
//  ----------+---------------------+-------------------+----------
//  request   | start / busy        | i_req (t_req)     | in
//  hit       | o_hit_valid strobe  | o_hit (t_res)     | out
//
// Write, remove and clear requests are applied without a scan; busy stays low.
// A tick keeps busy high through the scan state, one rule memory read per slot with
// the read data registered behind the address, then a done state that marks the last hit.
// A hit is held until the next one is found or the scan ends, so the last one
// can be marked. Hits are registered; the last shows in the first cycle with busy low.
// Reset clears control and valid bits only; memories need no pass.
// The receiver cannot stall; each hit strobe lasts one cycle.
module cron_schedule_matcher #(
    parameter int SLOTS = csm_pkg::Slots
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  csm_pkg::t_req i_req,
    output logic          o_hit_valid,
    output csm_pkg::t_res o_hit
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = ((IW > 4) ? IW : 4) + 1;
    localparam int HW = $clog2(csm_pkg::MaxHits + 1);

    // memories
    csm_pkg::t_rule rule_mem  [SLOTS];
    logic [31:0]    stamp_mem [SLOTS];
    csm_pkg::t_rule r_rule_q;
    logic [31:0]    r_stamp_q;
    csm_pkg::t_rule r_rule;

    csm_pkg::t_state r_state, n_state;
    logic [SLOTS-1:0] r_valid;
    logic [IW-1:0]    r_idx;
    logic [IW-1:0]    rd_addr;
    logic [31:0]      r_now;
    logic             r_time_ok;
    logic [59:0]      r_min_sel;
    logic [23:0]      r_hour_sel;
    logic [31:0]      r_day_sel;
    logic [12:0]      r_mon_sel;
    logic [6:0]       r_wk_sel;
    logic             r_pend_v;
    logic [3:0]       r_pend_slot;
    logic [HW-1:0]    r_nhit;
    logic             r_out_v, n_out_v;
    csm_pkg::t_res    r_out, n_out;

    logic accept, tick_acc, slot_ok, last_idx;
    logic scanning, finishing;
    logic dbit, wbit, match, fire, take;
    logic stamp_we;
    logic [IW-1:0] stamp_addr;
    logic [31:0]   stamp_wdata;
    logic time_ok_now;
    logic [5:0] t_min;
    logic [4:0] t_hour, t_day, t_mon;

    assign accept   = start && !busy;
    assign tick_acc = accept && (i_req.opcode == csm_pkg::OP_TICK);
    assign slot_ok  = CW'(i_req.slot) < CW'(SLOTS);
    assign last_idx = (r_idx == IW'(SLOTS - 1));

    assign t_min  = i_req.time_stamp[5:0];
    assign t_hour = i_req.time_stamp[10:6];
    assign t_day  = i_req.time_stamp[15:11];
    assign t_mon  = i_req.time_stamp[20:16];
    assign time_ok_now = (t_min <= csm_pkg::MinuteMax) && (t_hour <= csm_pkg::HourMax) &&
                         (t_day != 5'd0) && (t_mon != 5'd0) &&
                         (t_mon <= csm_pkg::MonthMax) &&
                         (i_req.weekday != csm_pkg::WeekdayNone);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            csm_pkg::ST_IDLE: if (tick_acc) n_state = csm_pkg::ST_SCAN;
            csm_pkg::ST_SCAN: if (last_idx) n_state = csm_pkg::ST_DONE;
            csm_pkg::ST_DONE: n_state = csm_pkg::ST_IDLE;
            default:          n_state = csm_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        busy      = 1'b0;
        scanning  = 1'b0;
        finishing = 1'b0;
        rd_addr   = '0;
        unique case (r_state)
            csm_pkg::ST_IDLE: rd_addr = '0;
            csm_pkg::ST_SCAN: begin
                busy     = 1'b1;
                scanning = 1'b1;
                rd_addr  = last_idx ? '0 : IW'(r_idx + 1'b1);
            end
            csm_pkg::ST_DONE: begin
                busy      = 1'b1;
                finishing = 1'b1;
            end
            default: busy = 1'b0;
        endcase
    end

    assign r_rule = r_rule_q;

    // match of the slot whose memory words are on r_rule_q / r_stamp_q
    always_comb begin
        dbit  = |(r_rule.day_mask & r_day_sel);
        wbit  = |(r_rule.week_mask & r_wk_sel);
        match = r_time_ok &&
                (|(r_rule.minute_mask & r_min_sel)) &&
                (|(r_rule.hour_mask & r_hour_sel)) &&
                (|(r_rule.month_mask & r_mon_sel)) &&
                ((r_rule.restrict_flags == 2'b11) ? (dbit || wbit) : (dbit && wbit));
        fire  = scanning && r_valid[r_idx] && (r_stamp_q != r_now) && match;
        take  = fire && (r_nhit < HW'(csm_pkg::MaxHits));
    end

    // a hit leaves when the next one is found, or at the end marked last
    always_comb begin
        n_out_v = (take && r_pend_v) || (finishing && r_pend_v);
        n_out   = '{hit_slot: r_pend_slot, last_hit: finishing};
    end

    // stamp writes: cleared by a rule write, set by a firing slot. The read of
    // the next slot never targets the entry written in the same cycle.
    always_comb begin
        stamp_we    = 1'b0;
        stamp_addr  = r_idx;
        stamp_wdata = r_now;
        if (fire) begin
            stamp_we = 1'b1;
        end else if (accept && (i_req.opcode == csm_pkg::OP_WRITE) && slot_ok) begin
            stamp_we    = 1'b1;
            stamp_addr  = IW'(i_req.slot);
            stamp_wdata = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && (i_req.opcode == csm_pkg::OP_WRITE) && slot_ok) begin
            rule_mem[IW'(i_req.slot)] <= '{minute_mask:    i_req.minute_mask,
                                          hour_mask:      i_req.hour_mask,
                                          day_mask:       i_req.day_mask,
                                          month_mask:     i_req.month_mask,
                                          week_mask:      i_req.week_mask,
                                          restrict_flags: i_req.restrict_flags,
                                          oneshot:        i_req.oneshot};
        end
        r_rule_q <= rule_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (stamp_we) begin
            stamp_mem[stamp_addr] <= stamp_wdata;
        end
        r_stamp_q <= stamp_mem[rd_addr];
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= csm_pkg::ST_IDLE;
            r_valid  <= '0;
            r_idx    <= '0;
            r_pend_v <= 1'b0;
            r_nhit   <= '0;
            r_out_v  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_out_v <= n_out_v;
            if (accept) begin
                unique case (i_req.opcode)
                    csm_pkg::OP_TICK: begin
                        r_idx    <= '0;
                        r_pend_v <= 1'b0;
                        r_nhit   <= '0;
                    end
                    csm_pkg::OP_WRITE:  if (slot_ok) r_valid[IW'(i_req.slot)] <= 1'b1;
                    csm_pkg::OP_REMOVE: if (slot_ok) r_valid[IW'(i_req.slot)] <= 1'b0;
                    csm_pkg::OP_CLEAR:  r_valid <= '0;
                    default:            r_valid <= r_valid;
                endcase
            end
            if (scanning) begin
                r_idx <= IW'(r_idx + 1'b1);
                if (fire && r_rule.oneshot) begin
                    r_valid[r_idx] <= 1'b0;
                end
                if (take) begin
                    r_pend_v <= 1'b1;
                    r_nhit   <= HW'(r_nhit + 1'b1);
                end
            end
            if (finishing) begin
                r_pend_v <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (take) begin
            r_pend_slot <= 4'(r_idx);
        end
        if (tick_acc) begin
            r_now      <= i_req.time_stamp;
            r_time_ok  <= time_ok_now;
            r_min_sel  <= 60'(1) << t_min;
            r_hour_sel <= 24'(1) << t_hour;
            r_day_sel  <= 32'(1) << t_day;
            r_mon_sel  <= 13'(1) << t_mon;
            r_wk_sel   <= 7'(1) << i_req.weekday;
        end
    end

    assign o_hit_valid = r_out_v;
    assign o_hit       = r_out;

endmodule

// ===== sv/csm_checker.sv =====
// Port-level checks for cron_schedule_matcher, bound to the top level.
// Depends on csm_pkg.
module csm_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input csm_pkg::t_req i_req,
    input logic          o_hit_valid,
    input csm_pkg::t_res o_hit
);

    // a tick request keeps the block busy for its scan; table edits do not
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_req.opcode == csm_pkg::OP_TICK) |=> busy)
        else $error("tick request did not start a scan");

    a_edit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_req.opcode != csm_pkg::OP_TICK) |=> !busy)
        else $error("table edit raised busy");

    // the last hit of a tick closes the burst
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_hit_valid && o_hit.last_hit |=> !o_hit_valid)
        else $error("hit after the last hit of a tick");

    // a hit that is not the last comes while the scan is still running
    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_hit_valid && !o_hit.last_hit |-> busy)
        else $error("non-final hit outside a scan");

endmodule

bind cron_schedule_matcher csm_checker u_csm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_req       (i_req),
    .o_hit_valid (o_hit_valid),
    .o_hit       (o_hit)
);

// ===== bench/cron_schedule_matcher_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for cron_schedule_matcher: directed rule and tick tests, then
// random request traffic checked against an in-bench rule table predictor.
// Depends on csm_pkg and cron_schedule_matcher.
module cron_schedule_matcher_tb;

    localparam int CycleLimit = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic start;
    logic busy;
    csm_pkg::t_req i_req;
    logic o_hit_valid;
    csm_pkg::t_res o_hit;

    // predictor state
    csm_pkg::t_rule rule_mem [csm_pkg::Slots];
    logic [31:0]    rule_stamp [csm_pkg::Slots];
    logic [csm_pkg::Slots-1:0] rule_live = '0;

    csm_pkg::t_res pending_hits [$];
    csm_pkg::t_res hit_want;
    int            error_count = 0;
    int            sender_idle_pct = 16;
    logic [31:0]   recent_stamp = '0;

    cron_schedule_matcher u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_hit_valid (o_hit_valid),
        .o_hit       (o_hit)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        for (int s = 0; s < csm_pkg::Slots; s++) begin
            rule_mem[s] = '0;
            rule_stamp[s] = '0;
        end
    end

    // Updates the rule table for one accepted request and queues the hits it causes.
    function automatic void apply_request(csm_pkg::t_req r);
        logic [5:0]                mi;
        logic [4:0]                hr;
        logic [4:0]                dy;
        logic [4:0]                mo;
        logic [2:0]                wk;
        logic                      in_range;
        logic                      dbit;
        logic                      wbit;
        logic [csm_pkg::Slots-1:0] fire;
        int                        last_idx;
        csm_pkg::t_res             entry;

        case (r.opcode)
            csm_pkg::OP_WRITE: begin
                rule_mem[r.slot].minute_mask    = r.minute_mask;
                rule_mem[r.slot].hour_mask      = r.hour_mask;
                rule_mem[r.slot].day_mask       = r.day_mask;
                rule_mem[r.slot].month_mask     = r.month_mask;
                rule_mem[r.slot].week_mask      = r.week_mask;
                rule_mem[r.slot].restrict_flags = r.restrict_flags;
                rule_mem[r.slot].oneshot        = r.oneshot;
                rule_stamp[r.slot] = '0;
                rule_live[r.slot] = 1'b1;
            end
            csm_pkg::OP_REMOVE: begin
                rule_live[r.slot] = 1'b0;
            end
            csm_pkg::OP_CLEAR: begin
                rule_live = '0;
            end
            default: begin
                mi = r.time_stamp[5:0];
                hr = r.time_stamp[10:6];
                dy = r.time_stamp[15:11];
                mo = r.time_stamp[20:16];
                wk = r.weekday;
                in_range = (mi <= csm_pkg::MinuteMax) && (hr <= csm_pkg::HourMax)
                           && (dy != 0) && (mo != 0) && (mo <= csm_pkg::MonthMax)
                           && (wk != csm_pkg::WeekdayNone);
                fire = '0;
                last_idx = -1;
                for (int s = 0; s < csm_pkg::Slots; s++) begin
                    if (in_range && rule_live[s] && rule_stamp[s] != r.time_stamp) begin
                        dbit = rule_mem[s].day_mask[dy];
                        wbit = rule_mem[s].week_mask[wk];
                        // both restriction flags set: day OR weekday
                        if (rule_mem[s].minute_mask[mi] && rule_mem[s].hour_mask[hr]
                            && rule_mem[s].month_mask[mo]
                            && ((rule_mem[s].restrict_flags == 2'b11) ? (dbit || wbit)
                                                                       : (dbit && wbit))) begin
                            fire[s] = 1'b1;
                            last_idx = s;
                            rule_stamp[s] = r.time_stamp;
                            if (rule_mem[s].oneshot)
                                rule_live[s] = 1'b0;
                        end
                    end
                end
                for (int s = 0; s < csm_pkg::Slots; s++) begin
                    if (fire[s]) begin
                        entry.hit_slot = 4'(s);
                        entry.last_hit = (s == last_idx);
                        pending_hits.push_back(entry);
                    end
                end
            end
        endcase
    endfunction

    // Hit checker: every strobe must match the oldest queued hit.
    always @(posedge i_clk) begin
        if (i_rst_n && o_hit_valid) begin
            if (pending_hits.size() == 0) begin
                $error("unexpected hit: hit_slot %0d last_hit %0b", o_hit.hit_slot,
                       o_hit.last_hit);
                error_count++;
            end else begin
                hit_want = pending_hits.pop_front();
                if (o_hit.hit_slot !== hit_want.hit_slot) begin
                    $error("hit_slot: expected %0d, actual %0d", hit_want.hit_slot,
                           o_hit.hit_slot);
                    error_count++;
                end
                if (o_hit.last_hit !== hit_want.last_hit) begin
                    $error("last_hit: expected %0b, actual %0b", hit_want.last_hit,
                           o_hit.last_hit);
                    error_count++;
                end
            end
        end
    end

    initial begin
        repeat (CycleLimit) @(posedge i_clk);
        $display("cron_schedule_matcher regression: fail");
        $finish;
    end

    // ---------------- request builders ----------------

    function automatic csm_pkg::t_req noise_req();
        logic [191:0] raw;
        raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
        return raw[179:0];
    endfunction

    function automatic logic [31:0] make_stamp(logic [10:0] yr, logic [4:0] mo,
                                               logic [4:0] dy, logic [4:0] hr,
                                               logic [5:0] mi);
        return {yr, mo, dy, hr, mi};
    endfunction

    function automatic csm_pkg::t_req make_tick(logic [31:0] stamp, logic [2:0] wk);
        csm_pkg::t_req r;
        r = noise_req();
        r.opcode = csm_pkg::OP_TICK;
        r.time_stamp = stamp;
        r.weekday = wk;
        return r;
    endfunction

    function automatic csm_pkg::t_req make_write(logic [3:0] slot, logic [59:0] mi_m,
                                                 logic [23:0] hr_m, logic [31:0] dy_m,
                                                 logic [12:0] mo_m, logic [6:0] wk_m,
                                                 logic [1:0] flags, logic os);
        csm_pkg::t_req r;
        r = noise_req();
        r.opcode = csm_pkg::OP_WRITE;
        r.slot = slot;
        r.minute_mask = mi_m;
        r.hour_mask = hr_m;
        r.day_mask = dy_m;
        r.month_mask = mo_m;
        r.week_mask = wk_m;
        r.restrict_flags = flags;
        r.oneshot = os;
        return r;
    endfunction

    function automatic csm_pkg::t_req make_op(logic [1:0] op, logic [3:0] slot);
        csm_pkg::t_req r;
        r = noise_req();
        r.opcode = op;
        r.slot = slot;
        return r;
    endfunction

    // mostly dense masks so ticks hit often
    function automatic logic [63:0] rand_mask();
        logic [63:0] a;
        logic [63:0] b;
        a = {$urandom(), $urandom()};
        b = {$urandom(), $urandom()};
        case ($urandom_range(3))
            0: return '1;
            3: return a & b;
            default: return a | b;
        endcase
    endfunction

    function automatic csm_pkg::t_req rand_write(logic [3:0] slot);
        logic [63:0] m0;
        logic [63:0] m1;
        logic [63:0] m2;
        logic [63:0] m3;
        logic [63:0] m4;
        m0 = rand_mask();
        m1 = rand_mask();
        m2 = rand_mask();
        m3 = rand_mask();
        m4 = rand_mask();
        return make_write(slot, m0[59:0], m1[23:0], m2[31:0], m3[12:0], m4[6:0],
                          2'($urandom_range(3)), ($urandom_range(3) == 0));
    endfunction

    function automatic csm_pkg::t_req rand_tick();
        int          pick;
        logic [31:0] stamp;
        logic [2:0]  wk;
        pick = $urandom_range(99);
        if (pick < 10)
            stamp = recent_stamp;               // repeat: last-stamp suppression
        else if (pick < 25)
            stamp = $urandom();
        else
            stamp = make_stamp(11'($urandom()), 5'($urandom_range(1, 12)),
                               5'($urandom_range(1, 31)), 5'($urandom_range(0, 23)),
                               6'($urandom_range(0, 59)));
        wk = ($urandom_range(19) == 0) ? csm_pkg::WeekdayNone : 3'($urandom_range(6));
        recent_stamp = stamp;
        return make_tick(stamp, wk);
    endfunction

    // ---------------- driving ----------------

    task automatic send_request(csm_pkg::t_req r);
        while ($urandom_range(99) < sender_idle_pct) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy !== 1'b0);
        apply_request(r);
    endtask

    task automatic hold_off();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_hits.size() != 0) @(posedge i_clk);
    endtask

    // ---------------- tests ----------------

    task automatic test_empty_table();
        send_request(make_tick(make_stamp(11'd0, 5'd1, 5'd1, 5'd0, 6'd0), 3'd0));
    endtask

    task automatic test_field_extremes();
        send_request(make_write(4'd0, '1, '1, '1, '1, '1, 2'b11, 1'b0));
        send_request(make_write(4'd15, '1, '1, '1, '1, '1, 2'b00, 1'b1));
        send_request(make_tick(make_stamp(11'd0, 5'd1, 5'd1, 5'd0, 6'd0), 3'd0));
        // same stamp again: nothing fires
        send_request(make_tick(make_stamp(11'd0, 5'd1, 5'd1, 5'd0, 6'd0), 3'd0));
        send_request(make_tick(make_stamp(11'h7ff, 5'd12, 5'd31, 5'd23, 6'd59), 3'd6));
    endtask

    task automatic test_out_of_range();
        send_request(make_tick(make_stamp(11'd1, 5'd3, 5'd3, 5'd3, 6'd60), 3'd1));
        send_request(make_tick(make_stamp(11'd1, 5'd3, 5'd3, 5'd24, 6'd3), 3'd1));
        send_request(make_tick(make_stamp(11'd1, 5'd3, 5'd0, 5'd3, 6'd3), 3'd1));
        send_request(make_tick(make_stamp(11'd1, 5'd0, 5'd3, 5'd3, 6'd3), 3'd1));
        send_request(make_tick(make_stamp(11'd1, 5'd13, 5'd3, 5'd3, 6'd3), 3'd1));
        send_request(make_tick(make_stamp(11'd1, 5'd3, 5'd3, 5'd3, 6'd3),
                               csm_pkg::WeekdayNone));
    endtask

    task automatic test_restrict_modes();
        // day 5 / weekday 2 only; slot 4 uses OR, slot 7 uses AND
        send_request(make_write(4'd4, '1, '1, 32'h20, '1, 7'h04, 2'b11, 1'b0));
        send_request(make_write(4'd7, '1, '1, 32'h20, '1, 7'h04, 2'b01, 1'b0));
        send_request(make_tick(make_stamp(11'd2, 5'd6, 5'd5, 5'd10, 6'd1), 3'd3));
        send_request(make_tick(make_stamp(11'd2, 5'd6, 5'd6, 5'd10, 6'd2), 3'd2));
        send_request(make_tick(make_stamp(11'd2, 5'd6, 5'd5, 5'd10, 6'd3), 3'd2));
    endtask

    task automatic test_remove_and_clear();
        send_request(make_op(csm_pkg::OP_REMOVE, 4'd0));
        send_request(make_op(csm_pkg::OP_REMOVE, 4'd9));
        send_request(make_tick(make_stamp(11'd2, 5'd6, 5'd5, 5'd10, 6'd4), 3'd2));
        hold_off();
        // rewrite clears the last stamp, so the old stamp fires again
        send_request(make_write(4'd15, '1, '1, '1, '1, '1, 2'b10, 1'b0));
        send_request(make_tick(make_stamp(11'd0, 5'd1, 5'd1, 5'd0, 6'd0), 3'd0));
        send_request(make_op(csm_pkg::OP_CLEAR, 4'd0));
        send_request(make_tick(make_stamp(11'd0, 5'd1, 5'd1, 5'd0, 6'd1), 3'd0));
    endtask

    task automatic test_random_traffic(int idle_pct, int n_items);
        int pick;
        sender_idle_pct = idle_pct;
        // fill the table so an in-range tick produces a hit from every slot
        for (int s = 0; s < csm_pkg::Slots; s++)
            send_request(make_write(4'(s), '1, '1, '1, '1, '1, 2'($urandom_range(3)), 1'b0));
        send_request(rand_tick());
        for (int i = 0; i < n_items; i++) begin
            pick = $urandom_range(99);
            if (pick < 45)
                send_request(rand_tick());
            else if (pick < 80)
                send_request(rand_write(4'($urandom_range(csm_pkg::Slots - 1))));
            else if (pick < 92)
                send_request(make_op(csm_pkg::OP_REMOVE,
                                     4'($urandom_range(csm_pkg::Slots - 1))));
            else if (pick < 95)
                send_request(make_op(csm_pkg::OP_CLEAR,
                                     4'($urandom_range(csm_pkg::Slots - 1))));
            else if (pick < 98)
                send_request(noise_req());
            else
                hold_off();
        end
        hold_off();
    endtask

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_req = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_table();
        test_field_extremes();
        test_out_of_range();
        test_restrict_modes();
        test_remove_and_clear();
        hold_off();
        test_random_traffic(16, 66);
        test_random_traffic(72, 66);
        test_random_traffic(0, 66);

        hold_off();
        repeat (csm_pkg::Slots + 4) @(posedge i_clk);
        if (pending_hits.size() != 0) begin
            $error("%0d hits never arrived", pending_hits.size());
            error_count++;
        end
        if (error_count == 0)
            $display("cron_schedule_matcher regression: pass");
        else
            $display("cron_schedule_matcher regression: fail");
        $finish;
    end

endmodule
